// ----- hdl/uart_baud_divisor_search_top_macros.svh -----
// Assertion macros used by the UART baud divisor search port checker.
`ifndef UART_BAUD_DIVISOR_SEARCH_TOP_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UBDS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ubds check failed");

// Next-cycle implication, disabled during reset.
`define UBDS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ubds check failed");

`endif

// ----- hdl/ubds_pkg.sv -----
// Types and constants of the UART baud divisor search block.
package ubds_pkg;

  localparam int BAUD_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int PCT_W      = 7;
  localparam int DIVB_W     = 8;
  localparam int DIV_CNT_W  = 5;
  localparam int ERR_PROD_W = BAUD_W + PCT_W;

  typedef logic [BAUD_W-1:0]     baud_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;
  typedef logic [PCT_W-1:0]      pct_t;
  typedef logic [DIVB_W-1:0]     divb_t;

  // register indexes
  localparam reg_idx_t REG_REF_CLOCK   = 3'd0;
  localparam reg_idx_t REG_PREDIV_EN   = 3'd1;
  localparam reg_idx_t REG_MIN_BAUD    = 3'd2;
  localparam reg_idx_t REG_MAX_BAUD    = 3'd3;
  localparam reg_idx_t REG_MAX_ERR_PCT = 3'd4;

  // register reset values
  localparam baud_t RST_REF_CLOCK   = 32'd100000000;
  localparam baud_t RST_MIN_BAUD    = 32'd110;
  localparam baud_t RST_MAX_BAUD    = 32'd921600;
  localparam pct_t  RST_MAX_ERR_PCT = 7'd3;

  // last step of the bit-serial divider
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;
  localparam logic [PCT_W-1:0]     PCT_SCALE = 7'd100;

endpackage

// ----- hdl/uart_baud_divisor_search_top.sv -----
// UART baud divisor search: bit-serial division over all candidate bit divisors.
// Out-of-range request: result in the cycle after the start transfer. In range:
// pre-divider division (when on), accumulation of rate*(MIN_BIT_DIV+1), then per divisor
// a load, a division, a shift-add multiply by d+1 and a second division (both skipped
// when gen is zero), then the checks. One request at a time (busy high through done).
// Synchronous reset returns registers to their defaults and the search to idle.
module uart_baud_divisor_search_top #(
  parameter int MIN_BIT_DIV  = 4,
  parameter int DIV_LIMIT    = 255,
  parameter int CLOCK_PREDIV = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ubds_pkg::baud_t      requested_baud,
  input  logic                 wr_en,
  input  ubds_pkg::reg_idx_t   wr_index,
  input  ubds_pkg::cfg_data_t  wr_data,
  output logic                 done,
  output logic                 accepted,
  output ubds_pkg::baud_t      rate_generator_value,
  output ubds_pkg::divb_t      bit_divisor,
  output ubds_pkg::baud_t      rate_error
);
  import ubds_pkg::*;

  localparam int STEP_W = $clog2(DIV_LIMIT + 1);
  localparam int PW     = BAUD_W + STEP_W;

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(MIN_BIT_DIV + 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(DIV_LIMIT);

  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREDIV = 4'd1;
  localparam logic [3:0] S_ACCUM  = 4'd2;
  localparam logic [3:0] S_LOAD1  = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV2   = 4'd6;
  localparam logic [3:0] S_NEXT   = 4'd7;
  localparam logic [3:0] S_CHECK1 = 4'd8;
  localparam logic [3:0] S_CHECK2 = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;

  // configuration registers
  baud_t ref_clock_hz;
  logic  clock_prediv_enable;
  baud_t min_baud;
  baud_t max_baud;
  pct_t  max_error_percent;

  // search registers
  baud_t             rate;
  baud_t             clk_eff;
  logic [PW-1:0]     prod;
  logic [STEP_W-1:0] steps;
  baud_t             gen;
  baud_t             achieved;
  baud_t             mul_a;
  logic [STEP_W-1:0] mul_b;
  baud_t             mul_acc;
  logic              found;
  baud_t             best_gen;
  divb_t             best_div;
  baud_t             best_err;
  logic              ok;
  logic [ERR_PROD_W-1:0] err_scaled;

  // bit-serial restoring divider
  baud_t                dv_num;
  logic [PW-1:0]        dv_rem;
  logic [PW-1:0]        dv_den;
  baud_t                dv_q;
  logic [DIV_CNT_W-1:0] dv_cnt;

  logic [PW:0]   dv_trial;
  logic          dv_fits;
  logic [PW-1:0] dv_rem_next;
  baud_t         dv_q_next;
  logic          dv_last;

  always_comb begin
    dv_trial    = {dv_rem, dv_num[BAUD_W-1]};
    dv_fits     = dv_trial >= {1'b0, dv_den};
    dv_rem_next = dv_fits ? PW'(dv_trial - {1'b0, dv_den}) : PW'(dv_trial);
    dv_q_next   = {dv_q[BAUD_W-2:0], dv_fits};
    dv_last     = dv_cnt == DIV_LAST;
  end

  // error of the current candidate
  baud_t err_c;
  logic  better;
  logic  in_range;
  logic  step_last;

  always_comb begin
    err_c     = (rate > achieved) ? (rate - achieved) : (achieved - rate);
    better    = (gen != '0) && (!found || err_c < best_err);
    in_range  = (requested_baud != '0) && (requested_baud >= min_baud) &&
                (requested_baud <= max_baud);
    step_last = steps == STEP_LAST;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz        <= RST_REF_CLOCK;
      clock_prediv_enable <= 1'b0;
      min_baud            <= RST_MIN_BAUD;
      max_baud            <= RST_MAX_BAUD;
      max_error_percent   <= RST_MAX_ERR_PCT;
    end else if (wr_en) begin
      case (wr_index)
        REG_REF_CLOCK:   ref_clock_hz        <= wr_data;
        REG_PREDIV_EN:   clock_prediv_enable <= wr_data[0];
        REG_MIN_BAUD:    min_baud            <= wr_data;
        REG_MAX_BAUD:    max_baud            <= wr_data;
        REG_MAX_ERR_PCT: max_error_percent   <= wr_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (!in_range)                state <= S_DONE;
            else if (clock_prediv_enable) state <= S_PREDIV;
            else                          state <= S_ACCUM;
          end
        end
        S_PREDIV: if (dv_last) state <= S_ACCUM;
        S_ACCUM:  if (steps == STEP_FIRST) state <= S_LOAD1;
        S_LOAD1:  state <= S_DIV1;
        S_DIV1: begin
          if (dv_last) state <= (dv_q_next == '0) ? S_NEXT : S_MUL;
        end
        S_MUL:    if (mul_b == '0) state <= S_DIV2;
        S_DIV2:   if (dv_last) state <= S_NEXT;
        S_NEXT:   state <= step_last ? S_CHECK1 : S_LOAD1;
        S_CHECK1: state <= found ? S_CHECK2 : S_DONE;
        S_CHECK2: state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rate     <= requested_baud;
        clk_eff  <= ref_clock_hz;
        prod     <= PW'(requested_baud);
        steps    <= STEP_W'(1);
        found    <= 1'b0;
        best_gen <= '0;
        best_div <= '0;
        best_err <= '1;
        ok       <= 1'b0;
        gen      <= '0;
        dv_num   <= ref_clock_hz;
        dv_rem   <= '0;
        dv_q     <= '0;
        dv_cnt   <= '0;
        dv_den   <= PW'(CLOCK_PREDIV);
      end
      S_PREDIV: begin
        dv_num <= dv_num << 1;
        dv_rem <= dv_rem_next;
        dv_q   <= dv_q_next;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) clk_eff <= dv_q_next;
      end
      S_ACCUM: begin
        if (steps != STEP_FIRST) begin
          prod  <= prod + PW'(rate);
          steps <= steps + 1'b1;
        end
      end
      S_LOAD1: begin
        dv_num <= clk_eff;
        dv_rem <= '0;
        dv_q   <= '0;
        dv_cnt <= '0;
        dv_den <= prod;
      end
      S_DIV1: begin
        dv_num <= dv_num << 1;
        dv_rem <= dv_rem_next;
        dv_q   <= dv_q_next;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          gen     <= dv_q_next;
          mul_a   <= dv_q_next;
          mul_b   <= steps;
          mul_acc <= '0;
        end
      end
      // shift-add gen*(d+1); the product never exceeds the clock
      S_MUL: begin
        if (mul_b == '0) begin
          dv_num <= clk_eff;
          dv_rem <= '0;
          dv_q   <= '0;
          dv_cnt <= '0;
          dv_den <= PW'(mul_acc);
        end else begin
          if (mul_b[0]) mul_acc <= mul_acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      S_DIV2: begin
        dv_num <= dv_num << 1;
        dv_rem <= dv_rem_next;
        dv_q   <= dv_q_next;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) achieved <= dv_q_next;
      end
      // keep the first candidate with the smallest error, then advance d
      S_NEXT: begin
        if (better) begin
          found    <= 1'b1;
          best_gen <= gen;
          best_div <= DIVB_W'(steps - 1'b1);
          best_err <= err_c;
        end
        prod  <= prod + PW'(rate);
        steps <= steps + 1'b1;
      end
      // percentage test at full product width
      S_CHECK1: err_scaled <= ERR_PROD_W'(best_err) * ERR_PROD_W'(PCT_SCALE);
      S_CHECK2: ok <= err_scaled <= ERR_PROD_W'(max_error_percent) * ERR_PROD_W'(rate);
      default: ;
    endcase
  end

  // result ports
  assign busy                 = state != S_IDLE;
  assign done                 = state == S_DONE;
  assign accepted             = ok;
  assign rate_generator_value = best_gen;
  assign bit_divisor          = best_div;
  assign rate_error           = best_err;

endmodule

// ----- hdl/ubds_checker.sv -----
// Port-level checks for the UART baud divisor search, bound to the top level.
`include "uart_baud_divisor_search_top_macros.svh"

module ubds_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        accepted,
  input logic [31:0] rate_generator_value,
  input logic [7:0]  bit_divisor,
  input logic [31:0] rate_error
);

  // a start transfer always makes the block busy
  `UBDS_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  // the result strobe comes at the end of a busy period
  `UBDS_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `UBDS_ASSERT_NXT(a_done_idle, clk, rst, done, !busy && !done)
  // no candidate found: empty result
  `UBDS_ASSERT_IMP(a_empty, clk, rst, done && bit_divisor == 8'd0,
                   !accepted && rate_generator_value == 32'd0 && rate_error == '1)
  // an accepted rate always names a real candidate
  `UBDS_ASSERT_IMP(a_acc_cand, clk, rst, done && accepted,
                   bit_divisor != 8'd0 && rate_generator_value != 32'd0)

endmodule

bind uart_baud_divisor_search_top ubds_checker u_ubds_checker (.*);

// ----- tb/baud_search_checker.sv -----
// Checker for the UART baud divisor search: predicts each result and compares it.
module baud_search_checker #(
  parameter int MIN_BIT_DIV  = 4,
  parameter int DIV_LIMIT    = 255,
  parameter int CLOCK_PREDIV = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  ubds_pkg::baud_t      requested_baud,
  input  logic                 wr_en,
  input  ubds_pkg::reg_idx_t   wr_index,
  input  ubds_pkg::cfg_data_t  wr_data,
  input  logic                 done,
  input  logic                 accepted,
  input  ubds_pkg::baud_t      rate_generator_value,
  input  ubds_pkg::divb_t      bit_divisor,
  input  ubds_pkg::baud_t      rate_error,
  output int                   mismatch_count,
  output int                   results_outstanding
);
  import ubds_pkg::*;

  typedef struct {
    logic  acc;
    baud_t gen;
    divb_t div;
    baud_t err;
  } search_result_t;

  // local copy of the register file
  baud_t clock_hz;
  logic  prediv_on;
  baud_t min_rate;
  baud_t max_rate;
  pct_t  err_pct;

  search_result_t expected_results[$];
  int             fails = 0;

  // best generator/divisor pair for one requested rate
  function automatic search_result_t best_divisor_for(input baud_t rate);
    logic [63:0]    clk_eff;
    logic [63:0]    steps;
    logic [63:0]    gen;
    logic [63:0]    achieved;
    logic [63:0]    err;
    logic [63:0]    best_err;
    logic           found;
    search_result_t r;
    r.acc    = 1'b0;
    r.gen    = '0;
    r.div    = '0;
    r.err    = '1;
    found    = 1'b0;
    best_err = 64'hFFFF_FFFF;
    if (rate != 0 && rate >= min_rate && rate <= max_rate) begin
      clk_eff = prediv_on ? 64'(clock_hz) / 64'(CLOCK_PREDIV) : 64'(clock_hz);
      for (int d = MIN_BIT_DIV; d < DIV_LIMIT; d++) begin
        steps = 64'(d) + 64'd1;
        gen   = clk_eff / (64'(rate) * steps);
        // a zero generator value is no candidate
        if (gen != 0) begin
          achieved = clk_eff / (gen * steps);
          err      = (64'(rate) > achieved) ? 64'(rate) - achieved : achieved - 64'(rate);
          if (!found || err < best_err) begin
            found    = 1'b1;
            r.gen    = gen[31:0];
            r.div    = 8'(d);
            best_err = err;
          end
        end
      end
      if (found) begin
        r.err = best_err[31:0];
        r.acc = (best_err * 64'd100) <= (64'(err_pct) * 64'(rate));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    search_result_t want;
    if (rst) begin
      clock_hz  = RST_REF_CLOCK;
      prediv_on = 1'b0;
      min_rate  = RST_MIN_BAUD;
      max_rate  = RST_MAX_BAUD;
      err_pct   = RST_MAX_ERR_PCT;
      expected_results.delete();
    end else begin
      // result side
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (accepted !== want.acc) begin
            $error("accepted: expected %0d, actual %0d", want.acc, accepted);
            fails++;
          end
          if (rate_generator_value !== want.gen) begin
            $error("rate_generator_value: expected %0d, actual %0d",
                   want.gen, rate_generator_value);
            fails++;
          end
          if (bit_divisor !== want.div) begin
            $error("bit_divisor: expected %0d, actual %0d", want.div, bit_divisor);
            fails++;
          end
          if (rate_error !== want.err) begin
            $error("rate_error: expected %0d, actual %0d", want.err, rate_error);
            fails++;
          end
        end
      end
      // request transfer
      if (start && !busy)
        expected_results.push_back(best_divisor_for(requested_baud));
      // register writes
      if (wr_en) begin
        case (wr_index)
          REG_REF_CLOCK:   clock_hz  = wr_data;
          REG_PREDIV_EN:   prediv_on = wr_data[0];
          REG_MIN_BAUD:    min_rate  = wr_data;
          REG_MAX_BAUD:    max_rate  = wr_data;
          REG_MAX_ERR_PCT: err_pct   = wr_data[PCT_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count      <= fails;
    results_outstanding <= expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the UART baud divisor search: stimulus, register setup and verdict.
module testbench;
  import ubds_pkg::*;

  localparam int MIN_BIT_DIV  = 4;
  localparam int DIV_LIMIT    = 255;
  localparam int CLOCK_PREDIV = 8;

  // index with no register behind it
  localparam reg_idx_t REG_UNUSED = 3'd7;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  baud_t     requested_baud;
  logic      wr_en;
  reg_idx_t  wr_index;
  cfg_data_t wr_data;
  logic      done;
  logic      accepted;
  baud_t     rate_generator_value;
  divb_t     bit_divisor;
  baud_t     rate_error;
  int        mismatch_count;
  int        results_outstanding;

  // settings kept only to shape the random requests
  baud_t shape_clock;
  logic  shape_prediv;
  baud_t shape_min;
  baud_t shape_max;
  logic  idle_gaps;

  baud_t default_rates[8] = '{32'd0, 32'd109, 32'd110, 32'd921600,
                              32'd921601, 32'hFFFF_FFFF, 32'd115200, 32'd9600};
  baud_t clock_choices[5] = '{32'd100000000, 32'd50000000, 32'd14745600,
                              32'd24000000, 32'd1843200};

  uart_baud_divisor_search_top #(
    .MIN_BIT_DIV  (MIN_BIT_DIV),
    .DIV_LIMIT    (DIV_LIMIT),
    .CLOCK_PREDIV (CLOCK_PREDIV)
  ) u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .requested_baud       (requested_baud),
    .wr_en                (wr_en),
    .wr_index             (wr_index),
    .wr_data              (wr_data),
    .done                 (done),
    .accepted             (accepted),
    .rate_generator_value (rate_generator_value),
    .bit_divisor          (bit_divisor),
    .rate_error           (rate_error)
  );

  baud_search_checker #(
    .MIN_BIT_DIV  (MIN_BIT_DIV),
    .DIV_LIMIT    (DIV_LIMIT),
    .CLOCK_PREDIV (CLOCK_PREDIV)
  ) u_search_check (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .requested_baud       (requested_baud),
    .wr_en                (wr_en),
    .wr_index             (wr_index),
    .wr_data              (wr_data),
    .done                 (done),
    .accepted             (accepted),
    .rate_generator_value (rate_generator_value),
    .bit_divisor          (bit_divisor),
    .rate_error           (rate_error),
    .mismatch_count       (mismatch_count),
    .results_outstanding  (results_outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one register write, only while the search is idle
  task automatic write_reg(input reg_idx_t idx, input cfg_data_t value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en    = 1'b0;
  endtask

  // one request transfer; start stays high until the next item or drain
  task automatic send_request(input baud_t rate);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    requested_baud = rate;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every predicted result has come and the block is idle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (results_outstanding != 0 || busy);
  endtask

  // mostly rates the search can reach, some boundaries, some raw words
  function automatic baud_t pick_rate();
    baud_t eff;
    baud_t upper;
    baud_t rate;
    eff   = shape_prediv ? shape_clock / CLOCK_PREDIV : shape_clock;
    upper = eff / (MIN_BIT_DIV + 1);
    case ($urandom_range(0, 9))
      0: rate = $urandom;
      1: rate = $urandom_range(0, 1) ? shape_min : shape_max;
      default: begin
        if (upper == 0)
          rate = $urandom_range(1, 16);
        else
          rate = $urandom_range(1, upper) >> $urandom_range(0, 16);
        if (rate < shape_min) rate = shape_min;
        if (rate > shape_max) rate = shape_max;
      end
    endcase
    return rate;
  endfunction

  task automatic configure_random();
    cfg_data_t prediv_word;
    cfg_data_t pct_word;
    case ($urandom_range(0, 3))
      0:       shape_clock = clock_choices[$urandom_range(0, 4)];
      1:       shape_clock = $urandom;
      2:       shape_clock = $urandom_range(1, 2000000);
      default: shape_clock = $urandom_range(10000000, 200000000);
    endcase
    prediv_word  = $urandom;
    shape_prediv = prediv_word[0];
    shape_min    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5000) : 32'd1;
    shape_max    = ($urandom_range(0, 3) == 0) ?
                   $urandom_range(shape_min, shape_min + 2000000) : 32'hFFFF_FFFF;
    pct_word     = ($urandom & 32'hFFFF_FF80) | $urandom_range(0, 127);
    idle_gaps    = ($urandom_range(0, 2) != 0);
    write_reg(REG_REF_CLOCK, shape_clock);
    write_reg(REG_PREDIV_EN, prediv_word);
    write_reg(REG_MIN_BAUD, shape_min);
    write_reg(REG_MAX_BAUD, shape_max);
    write_reg(REG_MAX_ERR_PCT, pct_word);
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    start          = 1'b0;
    requested_baud = '0;
    wr_en          = 1'b0;
    wr_index       = REG_REF_CLOCK;
    wr_data        = '0;
    idle_gaps      = 1'b1;
    // reset held over rising edges, then released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // defaults: zero, range edges, all-ones and common rates
    foreach (default_rates[i]) send_request(default_rates[i]);
    drain();

    // fastest clock with pre-divider, widest range, no error allowed
    write_reg(REG_REF_CLOCK, 32'hFFFF_FFFF);
    write_reg(REG_PREDIV_EN, 32'hFFFF_FFFF);
    write_reg(REG_MIN_BAUD, 32'd1);
    write_reg(REG_MAX_BAUD, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ERR_PCT, 32'd0);
    send_request(32'd1);
    send_request(32'h7FFF_FFFF);
    send_request(32'd3000000);
    send_request(32'd12345677);
    drain();

    // slow clock, zero minimum, percent above 100
    write_reg(REG_REF_CLOCK, 32'd1000);
    write_reg(REG_PREDIV_EN, 32'd0);
    write_reg(REG_MIN_BAUD, 32'd0);
    write_reg(REG_MAX_BAUD, 32'd1000);
    write_reg(REG_MAX_ERR_PCT, 32'hFFFF_FF7F);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(32'd0);
    send_request(32'd200);
    send_request(32'd7);
    send_request(32'd150);
    send_request(32'd1000);
    drain();

    // best candidate found but error over the limit
    write_reg(REG_MAX_ERR_PCT, 32'd10);
    send_request(32'd150);
    drain();

    // pre-divided clock of zero: nothing found
    write_reg(REG_REF_CLOCK, 32'd1);
    write_reg(REG_PREDIV_EN, 32'd1);
    send_request(32'd1);
    drain();

    // random settings, each with a batch of requests
    repeat (6) begin
      configure_random();
      repeat (15) send_request(pick_rate());
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // run limit
  initial begin
    #50000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- uart_baud_divisor_search_top.f -----
+incdir+hdl
hdl/ubds_pkg.sv
hdl/uart_baud_divisor_search_top.sv
hdl/ubds_checker.sv
tb/baud_search_checker.sv
tb/testbench.sv
